// File: hdl/assert_macros.svh
// Assertion helpers shared by the pretokenizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check an implication in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/tpt_pkg.sv
package tpt_pkg;

   localparam int unsigned CpWidth = 21;

   typedef logic [CpWidth-1:0] cp_type;
   typedef logic [2:0] kind_type;

   localparam kind_type KindWord  = 3'd0;
   localparam kind_type KindDigit = 3'd1;
   localparam kind_type KindCjk   = 3'd2;
   localparam kind_type KindPunct = 3'd3;
   localparam kind_type KindContr = 3'd4;
   localparam kind_type KindStart = 3'd5;
   localparam kind_type KindEnd   = 3'd6;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_WORD  = 2'd1,
      MODE_PUNCT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_EMIT = 2'd2
   } state_type;

   // One decision of the scanner on the head of the hold store
   typedef enum logic [1:0] {
      ACT_STALL = 2'd0,
      ACT_STEP  = 2'd1,
      ACT_DONE  = 2'd2
   } act_type;

   // Command from controller to datapath
   typedef struct packed {
      logic load;     // append the accepted request codepoint
      logic flush;    // the request is an end-of-text mark
      logic step;     // apply the current scan decision
      logic finish;   // clear state after a flush
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      act_type act;      // what the scan decision would do
      logic    emits;    // the decision produces a result this step
      logic    more;     // decision produces further results after this one
   } stat_type;

   localparam int unsigned StartLen = 15;
   localparam int unsigned EndLen   = 13;

   function automatic logic [7:0] start_char(input logic [3:0] i);
      logic [7:0] r;
      unique case (i)
         4'd0:  r = 8'h3C;
         4'd1:  r = 8'h7C;
         4'd2:  r = 8'h73;
         4'd3:  r = 8'h74;
         4'd4:  r = 8'h61;
         4'd5:  r = 8'h72;
         4'd6:  r = 8'h74;
         4'd7:  r = 8'h6F;
         4'd8:  r = 8'h66;
         4'd9:  r = 8'h74;
         4'd10: r = 8'h65;
         4'd11: r = 8'h78;
         4'd12: r = 8'h74;
         4'd13: r = 8'h7C;
         4'd14: r = 8'h3E;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] end_char(input logic [3:0] i);
      logic [7:0] r;
      unique case (i)
         4'd0:  r = 8'h3C;
         4'd1:  r = 8'h7C;
         4'd2:  r = 8'h65;
         4'd3:  r = 8'h6E;
         4'd4:  r = 8'h64;
         4'd5:  r = 8'h6F;
         4'd6:  r = 8'h66;
         4'd7:  r = 8'h74;
         4'd8:  r = 8'h65;
         4'd9:  r = 8'h78;
         4'd10: r = 8'h74;
         4'd11: r = 8'h7C;
         4'd12: r = 8'h3E;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic is_space(input cp_type c);
      return c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D;
   endfunction

   function automatic logic is_digit(input cp_type c);
      return c >= 21'h30 && c <= 21'h39;
   endfunction

   function automatic logic is_letter(input cp_type c);
      return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A)
         || (c >= 21'h00C0 && c <= 21'h024F) || (c >= 21'h0370 && c <= 21'h04FF);
   endfunction

   function automatic logic is_cjk(input cp_type c);
      return (c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'h3040 && c <= 21'h30FF)
         || (c >= 21'hAC00 && c <= 21'hD7AF) || (c >= 21'h3400 && c <= 21'h4DBF)
         || (c >= 21'hF900 && c <= 21'hFAFF);
   endfunction

   function automatic logic is_punct(input cp_type c);
      return !(is_space(c) || is_letter(c) || is_digit(c) || is_cjk(c));
   endfunction

   function automatic cp_type to_lower(input cp_type c);
      cp_type r;
      r = c;
      if ((c >= 21'h41 && c <= 21'h5A)
            || (c >= 21'h00C0 && c <= 21'h00DE && c != 21'h00D7)) begin
         r = c + 21'h20;
      end
      return r;
   endfunction

endpackage

// File: hdl/tpt_ctrl.sv
`include "assert_macros.svh"

module tpt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_eot,
   input  logic               req_zero,
   output logic               req_ready,
   input  logic               out_free,
   output logic               out_push,
   output logic               out_last,
   input  tpt_pkg::stat_type  stat,
   output tpt_pkg::cmd_type   cmd
);
   import tpt_pkg::*;

   state_type state_ff, state_in;
   logic      flush_ff, flush_in;

   // Hold state and the flush flag of the current request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flush_ff <= flush_in;
      end
   end

   // Sequence one request: load, scan and emit until the decision stalls or ends
   always_comb begin
      state_in  = state_ff;
      flush_in  = flush_ff;
      cmd       = '0;
      req_ready = 1'b0;
      out_push  = 1'b0;
      out_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               flush_in = req_eot;
               if (req_eot || !req_zero) begin
                  cmd.load = !req_eot;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.flush = flush_ff;
            if (stat.act == ACT_STEP) begin
               if (stat.emits) begin
                  state_in = ST_EMIT;
               end else begin
                  cmd.step = 1'b1;
               end
            end else if (out_free) begin
               // End the request only once the held-back result can leave
               cmd.finish = flush_ff;
               state_in   = ST_IDLE;
            end
         end
         ST_EMIT: begin
            // Push one result once the output has room, then decide again
            cmd.flush = flush_ff;
            if (out_free) begin
               out_push  = 1'b1;
               cmd.step  = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ASSERT_IMPLIES(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE,
      "request accepted outside idle")
   `ASSERT_IMPLIES(a_push_emit, clock, reset, out_push, state_ff == ST_EMIT,
      "result pushed outside emit")
   `ASSERT_IMPLIES(a_last_push, clock, reset, out_last, out_push,
      "last flag without push")

endmodule

// File: hdl/tpt_dp.sv
`include "assert_macros.svh"

module tpt_dp #(
   parameter int unsigned HOLD_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  tpt_pkg::cmd_type   cmd,
   input  tpt_pkg::cp_type    in_cp,
   output tpt_pkg::stat_type  stat,
   output tpt_pkg::cp_type    res_cp,
   output tpt_pkg::kind_type  res_kind,
   output logic               res_ends
);
   import tpt_pkg::*;

   localparam int unsigned IdxW = $clog2(HOLD_DEPTH);
   localparam int unsigned CntW = $clog2(HOLD_DEPTH + 1);

   // Hold store as a shift queue; head is entry 0
   cp_type              held_ff [HOLD_DEPTH];
   cp_type              held_in [HOLD_DEPTH];
   logic [CntW-1:0]     count_ff, count_in;
   mode_type            mode_ff, mode_in;
   logic [1:0]          sub_ff, sub_in;   // position inside a multi-result emission
   logic [1:0]          drop;
   logic [3:0]          mprog_ff, mprog_in; // matched marker prefix length of start
   logic [3:0]          eprog_ff, eprog_in; // matched prefix length of end marker
   logic                sfail_ff, sfail_in, efail_ff, efail_in;

   cp_type c0, c1, c2;
   logic   h1, h2, h3;
   logic   fin;

   assign c0  = held_ff[0];
   assign c1  = held_ff[1];
   assign c2  = held_ff[2];
   assign h1  = count_ff >= CntW'(1);
   assign h2  = count_ff >= CntW'(2);
   assign h3  = count_ff >= CntW'(3);
   assign fin = cmd.flush;

   // Decide what the head of the store does
   always_comb begin
      logic contr1, contr2, s_full, e_full, s_pend, e_pend, s_busy, e_busy, cont;
      stat     = '0;
      res_cp   = c0;
      res_kind = KindPunct;
      res_ends = 1'b1;
      drop     = 2'd0;
      mode_in  = mode_ff;
      contr1 = c1 == 21'h73 || c1 == 21'h74 || c1 == 21'h6D || c1 == 21'h64;
      contr2 = c1 == 21'h72 || c1 == 21'h76 || c1 == 21'h6C;
      s_full = !sfail_ff && mprog_ff == 4'(StartLen) && count_ff >= CntW'(StartLen);
      e_full = !efail_ff && eprog_ff == 4'(EndLen) && count_ff >= CntW'(EndLen);
      s_pend = !sfail_ff && !s_full;
      e_pend = !efail_ff && !e_full;
      s_busy = !sfail_ff && mprog_ff < 4'(StartLen) && count_ff > CntW'(mprog_ff);
      e_busy = !efail_ff && eprog_ff < 4'(EndLen) && count_ff > CntW'(eprog_ff);
      cont   = (mode_ff == MODE_WORD) ? is_letter(c1) : is_punct(c1);
      if (!h1) begin
         stat.act = ACT_DONE;
      end else if (mode_ff != MODE_START) begin
         res_kind = (mode_ff == MODE_WORD) ? KindWord : KindPunct;
         if (!h2) begin
            if (fin) begin
               stat.act = ACT_STEP; stat.emits = 1'b1; drop = 2'd1;
               mode_in = MODE_START;
            end else begin
               stat.act = ACT_STALL;
            end
         end else begin
            stat.act = ACT_STEP; stat.emits = 1'b1; drop = 2'd1;
            res_ends = !cont;
            if (!cont) mode_in = MODE_START;
         end
      end else if (is_space(c0)) begin
         stat.act = ACT_STEP; drop = 2'd1;
      end else if (c0 == 21'h3C && (s_busy || e_busy)) begin
         // Wait while the marker match catches up with the held entries
         stat.act = ACT_STEP;
      end else if (c0 == 21'h3C && !fin && (s_pend || e_pend)) begin
         stat.act = ACT_STALL;
      end else if (c0 == 21'h3C && s_full) begin
         stat.act = ACT_STEP; stat.emits = 1'b1; drop = 2'd3;
         res_cp = '0; res_kind = KindStart;
      end else if (c0 == 21'h3C && e_full) begin
         stat.act = ACT_STEP; stat.emits = 1'b1; drop = 2'd3;
         res_cp = '0; res_kind = KindEnd;
      end else if (c0 == 21'h27 && !h2 && !fin) begin
         stat.act = ACT_STALL;
      end else if (c0 == 21'h27 && h2 && contr1) begin
         stat.act = ACT_STEP; stat.emits = 1'b1; stat.more = sub_ff == 2'd0;
         res_kind = KindContr;
         res_cp   = (sub_ff == 2'd0) ? c0 : c1;
         res_ends = sub_ff != 2'd0;
         drop     = (sub_ff == 2'd0) ? 2'd0 : 2'd2;
      end else if (c0 == 21'h27 && h2 && contr2 && !h3 && !fin) begin
         stat.act = ACT_STALL;
      end else if (c0 == 21'h27 && h3 && contr2
            && c2 == ((c1 == 21'h6C) ? 21'h6C : 21'h65)) begin
         stat.act = ACT_STEP; stat.emits = 1'b1; stat.more = sub_ff != 2'd2;
         res_kind = KindContr;
         res_cp   = (sub_ff == 2'd0) ? c0 : (sub_ff == 2'd1) ? c1 : c2;
         res_ends = sub_ff == 2'd2;
         drop     = (sub_ff == 2'd2) ? 2'd3 : 2'd0;
      end else if (is_letter(c0)) begin
         stat.act = ACT_STEP; mode_in = MODE_WORD;
      end else if (is_digit(c0)) begin
         stat.act = ACT_STEP; stat.emits = 1'b1; drop = 2'd1; res_kind = KindDigit;
      end else if (is_cjk(c0)) begin
         stat.act = ACT_STEP; stat.emits = 1'b1; drop = 2'd1; res_kind = KindCjk;
      end else begin
         stat.act = ACT_STEP; mode_in = MODE_PUNCT;
      end
   end

   // Advance the store: shift the head out, append the request, track marker match
   always_comb begin
      logic [4:0] k;
      logic [CntW-1:0] cnt;
      logic [IdxW:0] src;
      logic [4:0] ms;
      k = 5'd0;
      if (cmd.step) begin
         unique case (drop)
            2'd1: k = 5'd1;
            2'd2: k = 5'd2;
            2'd3: k = (res_kind == KindStart) ? 5'(StartLen)
                    : (res_kind == KindEnd) ? 5'(EndLen) : 5'd3;
            default: k = 5'd0;
         endcase
      end
      cnt      = count_ff - CntW'(k);
      count_in = cnt;
      sub_in   = sub_ff;
      mprog_in = mprog_ff;
      eprog_in = eprog_ff;
      sfail_in = sfail_ff;
      efail_in = efail_ff;
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         src = (IdxW+1)'(i) + (IdxW+1)'(k);
         held_in[i] = (32'(src) < HOLD_DEPTH) ? held_ff[src[IdxW-1:0]] : held_ff[i];
      end
      if (cmd.step) begin
         sub_in = (drop != 2'd0 || !stat.emits) ? 2'd0 : sub_ff + 2'd1;
         if (k != 5'd0) begin
            // Rescan the marker match of the new head over the store
            mprog_in = '0; eprog_in = '0; sfail_in = 1'b0; efail_in = 1'b0;
         end
      end
      if (cmd.load && count_ff < CntW'(HOLD_DEPTH)) begin
         held_in[count_ff[IdxW-1:0]] = to_lower(in_cp);
         count_in = count_ff + CntW'(1);
      end
      // Extend the marker match by one entry per cycle while the head is not shifted out
      if (!(cmd.step && k != 5'd0)) begin
         ms = 5'(mprog_ff);
         if (!sfail_ff && mprog_ff < 4'(StartLen) && count_ff > CntW'(ms)) begin
            if (held_ff[ms[IdxW-1:0]] == cp_type'(start_char(mprog_ff)))
               mprog_in = mprog_ff + 4'd1;
            else
               sfail_in = 1'b1;
         end
         ms = 5'(eprog_ff);
         if (!efail_ff && eprog_ff < 4'(EndLen) && count_ff > CntW'(ms)) begin
            if (held_ff[ms[IdxW-1:0]] == cp_type'(end_char(eprog_ff)))
               eprog_in = eprog_ff + 4'd1;
            else
               efail_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         count_in = '0; sub_in = '0;
         mprog_in = '0; eprog_in = '0; sfail_in = 1'b0; efail_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HOLD_DEPTH; i++) held_ff[i] <= held_in[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mode_ff  <= MODE_START;
         sub_ff   <= '0;
         mprog_ff <= '0;
         eprog_ff <= '0;
         sfail_ff <= 1'b0;
         efail_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         mode_ff  <= cmd.finish ? MODE_START : (cmd.step ? mode_in : mode_ff);
         sub_ff   <= sub_in;
         mprog_ff <= mprog_in;
         eprog_ff <= eprog_in;
         sfail_ff <= sfail_in;
         efail_ff <= efail_in;
      end
   end

   `ASSERT_IMPLIES(a_count_max, clock, reset, 1'b1, count_ff <= CntW'(HOLD_DEPTH),
      "hold count beyond depth")
   `ASSERT_NEXT(a_finish_clear, clock, reset, cmd.finish, count_ff == '0,
      "store not cleared after flush")

endmodule

// File: hdl/text_pretokenizer.sv
// Pretokenizer front end: one codepoint (or an end-of-text mark on tuser) per request,
// lowercased and split into word, digit, CJK, punctuation, contraction and
// marker tokens. A request is accepted in the idle state and then scanned; a zero
// codepoint is dropped as it is accepted. Each result passes the scan sequencer as
// a decision in the scan state, then a push in the emit state; a step that emits
// nothing (dropped whitespace, start of a run) is applied in the scan state itself,
// and a '<' at the head waits until each held entry has been compared with the
// markers (after a load only the new entry, after a shift the whole store again).
// A full output register stalls the sequencer, and a request ends only when the
// output can take its held-back result. Each result waits in a pending register
// until the next result or the end of the request settles its last flag;
// rsp_tlast marks the last result of a request.
module text_pretokenizer #(
   parameter int unsigned HOLD_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] codepoint, [23:21] zero
   input  logic        req_tuser,   // [0] end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [20:0] out_codepoint, [23:21] token_kind,
                                    // [24] ends_token, [31:25] zero
   output logic        rsp_tlast    // last result of the request
);
   import tpt_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   cp_type   res_cp;
   kind_type res_kind;
   logic     res_ends;
   logic     push, unused_last;
   logic     ctrl_ready;

   // A pending result is kept back until the next one or the end of the request
   logic       pend_ff;
   logic [24:0] pend_data_ff;
   logic       out_valid_ff, out_last_ff;
   logic [24:0] out_data_ff;
   logic       out_free;
   logic       req_done;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign req_tready = ctrl_ready && out_free && !pend_ff;

   tpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid && out_free && !pend_ff),
      .req_eot   (req_tuser),
      .req_zero  (req_tdata[20:0] == 21'd0),
      .req_ready (ctrl_ready),
      .out_free  (out_free),
      .out_push  (push),
      .out_last  (unused_last),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpt_dp #(.HOLD_DEPTH(HOLD_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .in_cp    (req_tdata[20:0]),
      .stat     (stat),
      .res_cp   (res_cp),
      .res_kind (res_kind),
      .res_ends (res_ends)
   );

   // The request finishes when the scan returns to idle without a push
   assign req_done = (cmd.finish || (!push && !cmd.step && !cmd.load && !ctrl_ready
                     && stat.act != ACT_STEP)) && !unused_last;

   // Move the pending result to the output, marking it last at request end
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         if (rsp_tready) out_valid_ff <= 1'b0;
         if (push) begin
            pend_ff <= 1'b1;
            if (pend_ff) begin
               out_valid_ff <= 1'b1;
               out_last_ff  <= 1'b0;
            end
         end else if (pend_ff && req_done && out_free) begin
            pend_ff      <= 1'b0;
            out_valid_ff <= 1'b1;
            out_last_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         pend_data_ff <= {res_ends, res_kind, res_cp};
         if (pend_ff) out_data_ff <= pend_data_ff;
      end else if (pend_ff && req_done && out_free) begin
         out_data_ff <= pend_data_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_data_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
